@@ src/cdb_pkg.sv @@
// shared types and constants for the cdb hash table builder
`timescale 1ns / 1ps
`default_nettype none
package cdb_pkg;

    localparam int NUM_BKT = 256;
    localparam int DVD_W = 24;
    localparam logic [31:0] START_POS = 32'd2048;
    localparam logic [33:0] SLOT_BYTES = 34'd8;
    localparam logic [7:0] LAST_BKT = 8'd255;

    localparam logic [1:0] KIND_ADD = 2'd0;
    localparam logic [1:0] KIND_SLOT = 2'd1;
    localparam logic [1:0] KIND_HDR = 2'd2;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_POS_OVF = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef enum logic {
        OP_ADD,
        OP_TAKE
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [31:0] hash;
        logic [33:0] len_sum;
    } t_cmd;

    typedef enum logic [1:0] {
        PH_COLLECT,
        PH_SLOTS,
        PH_HEADERS
    } t_phase;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ADD_INC,
        S_PFX_A,
        S_PFX_B,
        S_SORT_A,
        S_SORT_B,
        S_SORT_C,
        S_SEEK_A,
        S_SEEK_B,
        S_CLR,
        S_INS_A,
        S_INS_B,
        S_DIV,
        S_PRB_A,
        S_PRB_B,
        S_EMIT_A,
        S_EMIT_B,
        S_HDR_A,
        S_HDR_B
    } t_state;

endpackage
`default_nettype wire

@@ src/cdb_hash_table_builder.sv @@
// top level of the cdb hash table builder
// usage:
//   input channel (i_valid / o_stall) carries i_func with the add fields;
//   func 0 adds a record, func 1 asks for the next output item.
//   every input transfer gives exactly one output transfer (o_valid / i_stall).
//   a two-entry command queue sits in front of the engine, so inputs keep
//   flowing while a result waits in the output register.
// flow:
//   add: the record is stored, then its bucket count is raised; one record at a time.
//   first take: a prefix pass over the bucket counts and a sort pass over
//   the records, then the buckets are searched and built as below.
//   bucket build (on the take that reaches a bucket): the probe region of
//   2*count entries is cleared, then each record goes through the shared
//   remainder unit and probes linearly for a free slot.
// reset clears the record count, the bucket counts and the drain phase;
// the block is ready the cycle after reset. when the receiver stalls the
// result holds and the engine waits, while the queue still takes two items.
`timescale 1ns / 1ps
`default_nettype none
module cdb_hash_table_builder
    import cdb_pkg::*;
#(
    parameter int MAX_RECORDS = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_func,
    input  wire logic [31:0] i_key_hash,
    input  wire logic [31:0] i_key_length,
    input  wire logic [31:0] i_data_length,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_kind,
    output logic [1:0]       o_status,
    output logic [31:0]      o_word_one,
    output logic [31:0]      o_word_two,
    output logic             o_last
);

    logic cmd_valid, cmd_pop;
    t_cmd cmd;

    cdb_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_func        (i_func),
        .i_key_hash    (i_key_hash),
        .i_key_length  (i_key_length),
        .i_data_length (i_data_length),
        .o_cmd_valid   (cmd_valid),
        .o_cmd         (cmd),
        .i_cmd_pop     (cmd_pop)
    );

    cdb_back #(.MAX_RECORDS(MAX_RECORDS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_kind      (o_kind),
        .o_status    (o_status),
        .o_word_one  (o_word_one),
        .o_word_two  (o_word_two),
        .o_last      (o_last)
    );

endmodule
`default_nettype wire

@@ src/cdb_front.sv @@
// input side: classifies items into commands and queues them for the engine
`timescale 1ns / 1ps
`default_nettype none
module cdb_front
    import cdb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_func,
    input  wire logic [31:0] i_key_hash,
    input  wire logic [31:0] i_key_length,
    input  wire logic [31:0] i_data_length,
    output logic             o_cmd_valid,
    output t_cmd             o_cmd,
    input  wire logic        i_cmd_pop
);

    localparam int DEPTH = 2;

    t_cmd       r_q [DEPTH];
    logic       r_wp, r_rp;
    logic [1:0] r_fill;
    logic       push;
    t_cmd       cmd_in;

    assign o_stall     = (r_fill == 2'(DEPTH));
    assign push        = i_valid && !o_stall;
    assign o_cmd_valid = (r_fill != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        cmd_in.op      = i_func ? OP_TAKE : OP_ADD;
        cmd_in.hash    = i_key_hash;
        cmd_in.len_sum = 34'(i_key_length) + 34'(i_data_length) + SLOT_BYTES;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (i_cmd_pop) r_rp <= r_rp + 1'b1;
            r_fill <= r_fill + 2'(push) - 2'(i_cmd_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= cmd_in;
    end

endmodule
`default_nettype wire

@@ src/cdb_mod.sv @@
// iterative remainder unit, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module cdb_mod
    import cdb_pkg::*;
#(
    parameter int LW = 12
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DVD_W-1:0] i_dividend,
    input  wire logic [LW-1:0]    i_divisor,
    output logic                  o_done,
    output logic [LW-1:0]         o_rem
);

    logic             r_busy, r_done;
    logic [4:0]       r_cnt;
    logic [LW-1:0]    r_rem;
    logic [DVD_W-1:0] r_dvd;
    logic [LW-1:0]    r_div;
    logic [LW:0]      trial;
    logic [LW:0]      t_sub;

    assign o_done = r_done;
    assign o_rem  = r_rem;

    always_comb begin
        trial = {r_rem, r_dvd[DVD_W-1]};
        t_sub = (trial >= {1'b0, r_div}) ? trial - {1'b0, r_div} : trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == 5'(DVD_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= t_sub[LW-1:0];
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
        end
    end

endmodule
`default_nettype wire

@@ src/cdb_back.sv @@
// engine: record store, bucket sort, probe table build and drain
`timescale 1ns / 1ps
`default_nettype none
module cdb_back
    import cdb_pkg::*;
#(
    parameter int MAX_RECORDS = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cmd_valid,
    input  wire t_cmd        i_cmd,
    output logic             o_cmd_pop,
    input  wire logic        i_stall,
    output logic             o_valid,
    output logic [1:0]       o_kind,
    output logic [1:0]       o_status,
    output logic [31:0]      o_word_one,
    output logic [31:0]      o_word_two,
    output logic             o_last
);

    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam int IW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int LW = CW + 1;
    localparam int PW = $clog2(2 * MAX_RECORDS);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RECORDS);

    logic [63:0]   rec_mem  [MAX_RECORDS];
    logic [63:0]   sort_mem [MAX_RECORDS];
    logic [63:0]   prb_mem  [2 * MAX_RECORDS];
    logic [CW-1:0] cnt_mem  [NUM_BKT];
    logic [CW-1:0] fill_mem [NUM_BKT];

    t_state r_state, n_state;
    t_phase r_phase, n_phase;

    logic [CW-1:0]  r_count, n_count;
    logic [31:0]    r_end, n_end;
    logic [NUM_BKT-1:0] r_cvalid;
    logic [8:0]     r_bkt, n_bkt;
    logic           r_built, n_built;
    logic [CW-1:0]  r_sum, n_sum;
    logic [CW-1:0]  r_i, n_i;
    logic [CW-1:0]  r_start, n_start;
    logic [CW-1:0]  r_j, n_j;
    logic [CW-1:0]  r_k, n_k;
    logic [LW-1:0]  r_len, n_len;
    logic [LW-1:0]  r_s, n_s;
    logic [LW-1:0]  r_where, n_where;
    logic [31:0]    r_hdr_pos, n_hdr_pos;
    logic [7:0]     r_add_b, n_add_b;
    logic           r_out_valid;

    logic [63:0]    r_rec_rd, r_sort_rd, r_prb_rd;
    logic [CW-1:0]  r_cnt_rd, r_fill_rd;
    logic           r_cnt_vld;

    logic [1:0]     r_kind, r_status;
    logic [31:0]    r_w1, r_w2;
    logic           r_last;

    logic [CW-1:0]  eff_count;
    logic [31:0]    eff_end;
    logic [33:0]    add_next;
    logic [32:0]    tail;
    logic [CW-1:0]  cnt_val;
    logic [CW-1:0]  sort_idx;

    logic           dispatch, do_fresh;
    logic           rec_we, cnt_we, fill_we, sort_we, prb_we;
    logic [7:0]     cnt_ra, fill_ra, fill_wa;
    logic [CW-1:0]  fill_wd;
    logic [PW-1:0]  prb_ra, prb_wa;
    logic [63:0]    prb_wd;
    logic           emit;
    logic [1:0]     e_kind, e_status;
    logic [31:0]    e_w1, e_w2;
    logic           e_last;
    logic           div_start, div_done;
    logic [LW-1:0]  div_rem;

    cdb_mod #(.LW(LW)) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sort_rd[63:40]),
        .i_divisor  (r_len),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    assign dispatch  = (r_state == S_IDLE) && i_cmd_valid && !r_out_valid;
    assign eff_count = (r_phase == PH_COLLECT) ? r_count : '0;
    assign eff_end   = (r_phase == PH_COLLECT) ? r_end : START_POS;
    assign add_next  = 34'(eff_end) + i_cmd.len_sum;
    assign tail      = 33'(r_end) + 33'({r_count, 4'b0000});
    assign cnt_val   = r_cnt_vld ? r_cnt_rd : '0;
    assign sort_idx  = r_start + r_j;

    assign o_valid    = r_out_valid;
    assign o_kind     = r_kind;
    assign o_status   = r_status;
    assign o_word_one = r_w1;
    assign o_word_two = r_w2;
    assign o_last     = r_last;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (dispatch) begin
                    if (i_cmd.op == OP_ADD) begin
                        if (eff_count != MAX_CNT && add_next[33:32] == 2'b00)
                            n_state = S_ADD_INC;
                    end else begin
                        unique case (r_phase)
                            PH_COLLECT: if (!tail[32]) n_state = S_PFX_A;
                            PH_SLOTS:   n_state = r_built ? S_EMIT_A : S_SEEK_A;
                            default:    n_state = S_HDR_A;
                        endcase
                    end
                end
            end
            S_ADD_INC: n_state = S_IDLE;
            S_PFX_A:   n_state = S_PFX_B;
            S_PFX_B:   n_state = (r_bkt[7:0] == LAST_BKT) ? S_SORT_A : S_PFX_A;
            S_SORT_A:  n_state = (r_i == r_count) ? S_SEEK_A : S_SORT_B;
            S_SORT_B:  n_state = S_SORT_C;
            S_SORT_C:  n_state = S_SORT_A;
            S_SEEK_A:  n_state = r_bkt[8] ? S_HDR_A : S_SEEK_B;
            S_SEEK_B:  n_state = (cnt_val == '0) ? S_SEEK_A : S_CLR;
            S_CLR:     n_state = (r_s == r_len - LW'(1)) ? S_INS_A : S_CLR;
            S_INS_A:   n_state = S_INS_B;
            S_INS_B:   n_state = S_DIV;
            S_DIV:     n_state = div_done ? S_PRB_A : S_DIV;
            S_PRB_A:   n_state = S_PRB_B;
            S_PRB_B: begin
                if (r_prb_rd[31:0] != 32'd0) n_state = S_PRB_A;
                else if (r_j == r_k - CW'(1)) n_state = S_EMIT_A;
                else n_state = S_INS_A;
            end
            S_EMIT_A:  n_state = S_EMIT_B;
            S_EMIT_B:  n_state = S_IDLE;
            S_HDR_A:   n_state = S_HDR_B;
            S_HDR_B:   n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_end     = r_end;
        n_bkt     = r_bkt;
        n_built   = r_built;
        n_sum     = r_sum;
        n_i       = r_i;
        n_start   = r_start;
        n_j       = r_j;
        n_k       = r_k;
        n_len     = r_len;
        n_s       = r_s;
        n_where   = r_where;
        n_hdr_pos = r_hdr_pos;
        n_add_b   = r_add_b;
        o_cmd_pop = dispatch;
        do_fresh  = 1'b0;
        rec_we    = 1'b0;
        cnt_we    = 1'b0;
        fill_we   = 1'b0;
        sort_we   = 1'b0;
        prb_we    = 1'b0;
        cnt_ra    = r_bkt[7:0];
        fill_ra   = r_rec_rd[39:32];
        fill_wa   = r_bkt[7:0];
        fill_wd   = r_sum;
        prb_ra    = r_s[PW-1:0];
        prb_wa    = r_s[PW-1:0];
        prb_wd    = 64'd0;
        div_start = 1'b0;
        emit      = 1'b0;
        e_kind    = KIND_ADD;
        e_status  = ST_OK;
        e_w1      = 32'd0;
        e_w2      = 32'd0;
        e_last    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                cnt_ra = i_cmd.hash[7:0];
                if (dispatch) begin
                    if (i_cmd.op == OP_ADD) begin
                        emit = 1'b1;
                        e_w1 = eff_end;
                        if (r_phase != PH_COLLECT) do_fresh = 1'b1;
                        if (eff_count == MAX_CNT) begin
                            e_status = ST_FULL;
                            do_fresh = 1'b1;
                        end else if (add_next[33:32] != 2'b00) begin
                            e_status = ST_POS_OVF;
                            do_fresh = 1'b1;
                        end else begin
                            rec_we  = 1'b1;
                            e_w2    = add_next[31:0];
                            n_count = eff_count + CW'(1);
                            n_end   = add_next[31:0];
                            n_add_b = i_cmd.hash[7:0];
                        end
                    end else if (r_phase == PH_COLLECT) begin
                        if (tail[32]) begin
                            emit     = 1'b1;
                            e_kind   = KIND_SLOT;
                            e_status = ST_POS_OVF;
                            do_fresh = 1'b1;
                        end else begin
                            n_phase   = PH_SLOTS;
                            n_hdr_pos = r_end;
                            n_bkt     = 9'd0;
                            n_sum     = '0;
                            n_i       = '0;
                            n_start   = '0;
                            n_built   = 1'b0;
                        end
                    end
                end
            end
            S_ADD_INC: begin
                cnt_we = 1'b1;
            end
            S_PFX_B: begin
                fill_we = 1'b1;
                n_sum   = r_sum + cnt_val;
                n_bkt   = (r_bkt[7:0] == LAST_BKT) ? 9'd0 : r_bkt + 9'd1;
            end
            S_SORT_C: begin
                sort_we = 1'b1;
                fill_we = 1'b1;
                fill_wa = r_rec_rd[39:32];
                fill_wd = r_fill_rd + CW'(1);
                n_i     = r_i + CW'(1);
            end
            S_SEEK_A: begin
                if (r_bkt[8]) begin
                    n_phase = PH_HEADERS;
                    n_bkt   = 9'd0;
                end
            end
            S_SEEK_B: begin
                if (cnt_val == '0) begin
                    n_bkt = r_bkt + 9'd1;
                end else begin
                    n_k   = cnt_val;
                    n_len = {cnt_val, 1'b0};
                    n_s   = '0;
                end
            end
            S_CLR: begin
                prb_we = 1'b1;
                n_s    = r_s + LW'(1);
                n_j    = '0;
            end
            S_INS_B: begin
                div_start = 1'b1;
            end
            S_DIV: begin
                if (div_done) n_where = div_rem;
            end
            S_PRB_A: begin
                prb_ra = r_where[PW-1:0];
            end
            S_PRB_B: begin
                if (r_prb_rd[31:0] != 32'd0) begin
                    n_where = (r_where == r_len - LW'(1)) ? '0 : r_where + LW'(1);
                end else begin
                    prb_we = 1'b1;
                    prb_wa = r_where[PW-1:0];
                    prb_wd = r_sort_rd;
                    if (r_j == r_k - CW'(1)) begin
                        n_s     = '0;
                        n_built = 1'b1;
                    end else begin
                        n_j = r_j + CW'(1);
                    end
                end
            end
            S_EMIT_B: begin
                emit   = 1'b1;
                e_kind = KIND_SLOT;
                e_w1   = r_prb_rd[63:32];
                e_w2   = r_prb_rd[31:0];
                if (r_s == r_len - LW'(1)) begin
                    n_built = 1'b0;
                    n_start = r_start + r_k;
                    n_bkt   = r_bkt + 9'd1;
                end else begin
                    n_s = r_s + LW'(1);
                end
            end
            S_HDR_B: begin
                emit      = 1'b1;
                e_kind    = KIND_HDR;
                e_w1      = r_hdr_pos;
                e_w2      = 32'({cnt_val, 1'b0});
                e_last    = (r_bkt[7:0] == LAST_BKT);
                n_hdr_pos = r_hdr_pos + 32'({cnt_val, 4'b0000});
                if (r_bkt[7:0] == LAST_BKT) do_fresh = 1'b1;
                else n_bkt = r_bkt + 9'd1;
            end
            default: begin
            end
        endcase

        if (do_fresh && !rec_we) begin
            n_count = '0;
            n_end   = START_POS;
        end
        if (do_fresh) begin
            n_phase = PH_COLLECT;
            n_bkt   = 9'd0;
            n_built = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_COLLECT;
            r_count     <= '0;
            r_end       <= START_POS;
            r_cvalid    <= '0;
            r_bkt       <= 9'd0;
            r_built     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_count <= n_count;
            r_end   <= n_end;
            r_bkt   <= n_bkt;
            r_built <= n_built;
            if (do_fresh) r_cvalid <= '0;
            else if (cnt_we) r_cvalid[r_add_b] <= 1'b1;
            if (emit) r_out_valid <= 1'b1;
            else if (!i_stall) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum     <= n_sum;
        r_i       <= n_i;
        r_start   <= n_start;
        r_j       <= n_j;
        r_k       <= n_k;
        r_len     <= n_len;
        r_s       <= n_s;
        r_where   <= n_where;
        r_hdr_pos <= n_hdr_pos;
        r_add_b   <= n_add_b;
        r_cnt_vld <= r_cvalid[cnt_ra] && !do_fresh;
        if (emit) begin
            r_kind   <= e_kind;
            r_status <= e_status;
            r_w1     <= e_w1;
            r_w2     <= e_w2;
            r_last   <= e_last;
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (rec_we) rec_mem[eff_count[IW-1:0]] <= {i_cmd.hash, eff_end};
        r_rec_rd <= rec_mem[r_i[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (sort_we) sort_mem[r_fill_rd[IW-1:0]] <= r_rec_rd;
        r_sort_rd <= sort_mem[sort_idx[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) cnt_mem[r_add_b] <= cnt_val + CW'(1);
        r_cnt_rd <= cnt_mem[cnt_ra];
    end

    always_ff @(posedge i_clk) begin
        if (fill_we) fill_mem[fill_wa] <= fill_wd;
        r_fill_rd <= fill_mem[fill_ra];
    end

    always_ff @(posedge i_clk) begin
        if (prb_we) prb_mem[prb_wa] <= prb_wd;
        r_prb_rd <= prb_mem[prb_ra];
    end

endmodule
`default_nettype wire
